>>> src/cpc_pkg.sv
// Shared types, constants and the per-face step table of the convex polyhedron
// point classifier. Every other file of the block refers to this package by
// scoped names; it depends on nothing.
`default_nettype none

package cpc_pkg;

	// Table size and field widths.
	localparam int MAX_FACES  = 64;
	localparam int FACE_AW    = $clog2(MAX_FACES);
	localparam int FCNT_W     = 7;
	localparam int COORD_W    = 32;
	localparam int RES_W      = 31;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 31;

	// Arithmetic widths of the shared multiply-accumulate unit.
	localparam int OPND_W = 34;            // signed operand, holds a 33-bit unsigned limb
	localparam int PROD_W = 2 * OPND_W;
	localparam int ACC_W  = 132;           // holds |d|^2 - r^2*|S|^2 exactly
	localparam int DIFF_W = COORD_W + 1;   // p - center
	localparam int D_W    = 67;            // signed projection d
	localparam int MAG_W  = 65;            // |d|
	localparam int R2_W   = 2 * RES_W;     // resolution squared
	localparam int S2_W   = 2 * COORD_W;   // |S|^2
	localparam int LIMB_W = 32;

	// Sequencer step counter.
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_EVAL = 4'd14;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FACE_COUNT = 1'b1;

	// Codes of the action field.
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic                      action;
		logic [FACE_AW-1:0]        face_index;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic signed [COORD_W-1:0] area_x;
		logic signed [COORD_W-1:0] area_y;
		logic signed [COORD_W-1:0] area_z;
	} in_word_t;

	typedef struct packed {
		logic inside_res;
		logic not_outside;
		logic on_boundary;
	} out_word_t;

	// One row of the face table.
	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cz;
		logic signed [COORD_W-1:0] nx;
		logic signed [COORD_W-1:0] ny;
		logic signed [COORD_W-1:0] nz;
	} face_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	// Left shift applied to a product before it enters the accumulator.
	typedef enum logic [1:0] {
		SH_0,
		SH_32,
		SH_33,
		SH_64
	} shift_t;

	// Which intermediate value is captured when the operation retires.
	typedef enum logic [1:0] {
		SV_NONE,
		SV_R2,
		SV_S2,
		SV_D
	} save_t;

	// Operand sources of the multiplier.
	typedef enum logic [3:0] {
		OPD_ZERO,
		OPD_RES,
		OPD_NX,
		OPD_NY,
		OPD_NZ,
		OPD_DX,
		OPD_DY,
		OPD_DZ,
		OPD_R2LO,
		OPD_R2HI,
		OPD_S2LO,
		OPD_S2HI,
		OPD_MLO,
		OPD_MHI
	} opnd_t;

	// Control word that travels with a product through the shared unit.
	typedef struct packed {
		logic   acc_en;
		logic   clr;
		logic   sub;
		shift_t sh;
		save_t  sv;
	} mac_op_t;

	typedef struct packed {
		opnd_t   a;
		opnd_t   b;
		mac_op_t op;
	} step_ctrl_t;

	localparam mac_op_t MAC_NOP = '{1'b0, 1'b0, 1'b0, SH_0, SV_NONE};
	localparam mac_op_t MAC_R2  = '{1'b0, 1'b0, 1'b0, SH_0, SV_R2};

	// Per-face schedule. Steps 0-2 build |S|^2, 3-5 build d, 6-9 subtract
	// r^2*|S|^2 and 10-12 add |d|^2. Step 13 drains the product register and
	// step 14 judges the accumulated sign.
	function automatic step_ctrl_t step_op(input logic [STEP_W-1:0] step);
		step_ctrl_t c;
		c = '{OPD_ZERO, OPD_ZERO, MAC_NOP};
		unique case (step)
			4'd0:  c = '{OPD_NX,   OPD_NX,   '{1'b1, 1'b1, 1'b0, SH_0,  SV_NONE}};
			4'd1:  c = '{OPD_NY,   OPD_NY,   '{1'b1, 1'b0, 1'b0, SH_0,  SV_NONE}};
			4'd2:  c = '{OPD_NZ,   OPD_NZ,   '{1'b1, 1'b0, 1'b0, SH_0,  SV_NONE}};
			4'd3:  c = '{OPD_DX,   OPD_NX,   '{1'b1, 1'b1, 1'b0, SH_0,  SV_S2}};
			4'd4:  c = '{OPD_DY,   OPD_NY,   '{1'b1, 1'b0, 1'b0, SH_0,  SV_NONE}};
			4'd5:  c = '{OPD_DZ,   OPD_NZ,   '{1'b1, 1'b0, 1'b0, SH_0,  SV_NONE}};
			4'd6:  c = '{OPD_R2LO, OPD_S2LO, '{1'b1, 1'b1, 1'b1, SH_0,  SV_D}};
			4'd7:  c = '{OPD_R2LO, OPD_S2HI, '{1'b1, 1'b0, 1'b1, SH_32, SV_NONE}};
			4'd8:  c = '{OPD_R2HI, OPD_S2LO, '{1'b1, 1'b0, 1'b1, SH_32, SV_NONE}};
			4'd9:  c = '{OPD_R2HI, OPD_S2HI, '{1'b1, 1'b0, 1'b1, SH_64, SV_NONE}};
			4'd10: c = '{OPD_MLO,  OPD_MLO,  '{1'b1, 1'b0, 1'b0, SH_0,  SV_NONE}};
			4'd11: c = '{OPD_MHI,  OPD_MLO,  '{1'b1, 1'b0, 1'b0, SH_33, SV_NONE}};
			4'd12: c = '{OPD_MHI,  OPD_MHI,  '{1'b1, 1'b0, 1'b0, SH_64, SV_NONE}};
			default: c = '{OPD_ZERO, OPD_ZERO, MAC_NOP};
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> src/cpc_face_mem.sv
// Face table of the point classifier: one row per face, written by face
// loads and read with a registered output. Depends on cpc_pkg.
`default_nettype none

module cpc_face_mem (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [cpc_pkg::FACE_AW-1:0] waddr,
	input  wire cpc_pkg::face_t              wdata,
	input  wire logic [cpc_pkg::FACE_AW-1:0] raddr,
	output cpc_pkg::face_t                   rdata
);

	cpc_pkg::face_t mem_q [cpc_pkg::MAX_FACES];
	cpc_pkg::face_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> src/cpc_mac.sv
// Shared multiply-accumulate unit: a registered signed 34x34 multiplier
// followed by a shift and a 132-bit add or subtract. Depends on cpc_pkg.
`default_nettype none

module cpc_mac (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic signed [cpc_pkg::OPND_W-1:0]  opa,
	input  wire logic signed [cpc_pkg::OPND_W-1:0]  opb,
	input  wire cpc_pkg::mac_op_t                   op,
	output cpc_pkg::mac_op_t                        op_s1,
	output logic signed [cpc_pkg::PROD_W-1:0]       prod_s1,
	output logic [cpc_pkg::ACC_W-1:0]               acc_q
);

	logic [cpc_pkg::ACC_W-1:0] ext;
	logic [cpc_pkg::ACC_W-1:0] shifted;
	logic [cpc_pkg::ACC_W-1:0] base;
	logic [cpc_pkg::ACC_W-1:0] acc_d;

	always_ff @(posedge clk) begin
		prod_s1 <= opa * opb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= cpc_pkg::MAC_NOP;
		end else begin
			op_s1 <= op;
		end
	end

	always_comb begin
		ext = {{(cpc_pkg::ACC_W - cpc_pkg::PROD_W){prod_s1[cpc_pkg::PROD_W-1]}}, prod_s1};
		case (op_s1.sh)
			cpc_pkg::SH_32: shifted = ext << 32;
			cpc_pkg::SH_33: shifted = ext << 33;
			cpc_pkg::SH_64: shifted = ext << 64;
			default:        shifted = ext;
		endcase
		base  = op_s1.clr ? '0 : acc_q;
		acc_d = op_s1.sub ? (base - shifted) : (base + shifted);
	end

	always_ff @(posedge clk) begin
		if (op_s1.acc_en) begin
			acc_q <= acc_d;
		end
	end

endmodule

`default_nettype wire

>>> src/cpc_seq.sv
// Sequencer of the point classifier: walks the faces of a query, feeds the
// shared multiply-accumulate unit and folds each face verdict into the
// three result flags. Depends on cpc_pkg.
`default_nettype none

module cpc_seq (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               query_go,
	input  wire cpc_pkg::in_word_t                  cmd,
	input  wire logic [cpc_pkg::RES_W-1:0]          resolution,
	input  wire logic [cpc_pkg::FCNT_W-1:0]         face_count,
	input  wire cpc_pkg::face_t                     rd,
	output logic [cpc_pkg::FACE_AW-1:0]             rd_addr,
	output logic signed [cpc_pkg::OPND_W-1:0]       opa,
	output logic signed [cpc_pkg::OPND_W-1:0]       opb,
	output cpc_pkg::mac_op_t                        op,
	input  wire cpc_pkg::mac_op_t                   op_s1,
	input  wire logic signed [cpc_pkg::PROD_W-1:0]  prod_s1,
	input  wire logic [cpc_pkg::ACC_W-1:0]          acc_q,
	output logic                                    busy,
	output logic                                    done,
	output cpc_pkg::out_word_t                      result
);

	cpc_pkg::seq_state_t state_q, state_d;
	logic [cpc_pkg::STEP_W-1:0]        step_q;
	logic [cpc_pkg::FACE_AW-1:0]       face_q;
	logic [cpc_pkg::FACE_AW-1:0]       last_face_q;
	logic                              face_last;
	logic                              eval;
	cpc_pkg::step_ctrl_t               ctl;
	cpc_pkg::opnd_t                    sel_a, sel_b;
	logic [cpc_pkg::FCNT_W-1:0]        nfaces;
	logic [cpc_pkg::FCNT_W-1:0]        nlast;

	logic signed [cpc_pkg::COORD_W-1:0] px_q, py_q, pz_q;
	logic signed [cpc_pkg::DIFF_W-1:0]  dx_q, dy_q, dz_q;
	logic [cpc_pkg::R2_W-1:0]           r2_q;
	logic [cpc_pkg::S2_W-1:0]           s2_q;
	logic [cpc_pkg::MAG_W-1:0]          mag_q;
	logic                               neg_q, dnz_q;
	logic [cpc_pkg::D_W-1:0]            d_raw, d_abs;
	logic                               inside_q, nout_q, near_q;
	logic                               far, inside_n, nout_n, near_n;
	logic                               done_q;
	cpc_pkg::out_word_t                 result_q;

	function automatic logic signed [cpc_pkg::OPND_W-1:0] pick(
		input cpc_pkg::opnd_t sel,
		input logic [cpc_pkg::RES_W-1:0] res,
		input cpc_pkg::face_t f,
		input logic signed [cpc_pkg::DIFF_W-1:0] dx,
		input logic signed [cpc_pkg::DIFF_W-1:0] dy,
		input logic signed [cpc_pkg::DIFF_W-1:0] dz,
		input logic [cpc_pkg::R2_W-1:0] r2,
		input logic [cpc_pkg::S2_W-1:0] s2,
		input logic [cpc_pkg::MAG_W-1:0] mag
	);
		logic signed [cpc_pkg::OPND_W-1:0] v;
		v = '0;
		case (sel)
			cpc_pkg::OPD_RES:  v = cpc_pkg::OPND_W'(res);
			cpc_pkg::OPD_NX:   v = cpc_pkg::OPND_W'(f.nx);
			cpc_pkg::OPD_NY:   v = cpc_pkg::OPND_W'(f.ny);
			cpc_pkg::OPD_NZ:   v = cpc_pkg::OPND_W'(f.nz);
			cpc_pkg::OPD_DX:   v = cpc_pkg::OPND_W'(dx);
			cpc_pkg::OPD_DY:   v = cpc_pkg::OPND_W'(dy);
			cpc_pkg::OPD_DZ:   v = cpc_pkg::OPND_W'(dz);
			cpc_pkg::OPD_R2LO: v = cpc_pkg::OPND_W'(r2[cpc_pkg::LIMB_W-1:0]);
			cpc_pkg::OPD_R2HI: v = cpc_pkg::OPND_W'(r2[cpc_pkg::R2_W-1:cpc_pkg::LIMB_W]);
			cpc_pkg::OPD_S2LO: v = cpc_pkg::OPND_W'(s2[cpc_pkg::LIMB_W-1:0]);
			cpc_pkg::OPD_S2HI: v = cpc_pkg::OPND_W'(s2[cpc_pkg::S2_W-1:cpc_pkg::LIMB_W]);
			cpc_pkg::OPD_MLO:  v = cpc_pkg::OPND_W'(mag[cpc_pkg::LIMB_W-1:0]);
			cpc_pkg::OPD_MHI:  v = cpc_pkg::OPND_W'(mag[cpc_pkg::MAG_W-1:cpc_pkg::LIMB_W]);
			default:           v = '0;
		endcase
		return v;
	endfunction

	// Active faces, clipped to the table size.
	assign nfaces = (face_count > cpc_pkg::FCNT_W'(cpc_pkg::MAX_FACES)) ?
		cpc_pkg::FCNT_W'(cpc_pkg::MAX_FACES) : face_count;
	assign nlast     = nfaces - cpc_pkg::FCNT_W'(1);
	assign face_last = (face_q == last_face_q);
	assign eval      = (state_q == cpc_pkg::SEQ_RUN) && (step_q == cpc_pkg::STEP_EVAL);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cpc_pkg::SEQ_IDLE: begin
				if (query_go && (nfaces != '0)) begin
					state_d = cpc_pkg::SEQ_RUN;
				end
			end
			cpc_pkg::SEQ_RUN: begin
				if ((step_q == cpc_pkg::STEP_EVAL) && face_last) begin
					state_d = cpc_pkg::SEQ_IDLE;
				end
			end
			default: state_d = cpc_pkg::SEQ_IDLE;
		endcase
	end

	always_comb begin
		ctl     = cpc_pkg::step_op(step_q);
		busy    = 1'b0;
		sel_a   = cpc_pkg::OPD_ZERO;
		sel_b   = cpc_pkg::OPD_ZERO;
		op      = cpc_pkg::MAC_NOP;
		rd_addr = face_q;
		unique case (state_q)
			cpc_pkg::SEQ_IDLE: begin
				rd_addr = '0;
				if (query_go) begin
					sel_a = cpc_pkg::OPD_RES;
					sel_b = cpc_pkg::OPD_RES;
					op    = cpc_pkg::MAC_R2;
				end
			end
			cpc_pkg::SEQ_RUN: begin
				busy  = 1'b1;
				sel_a = ctl.a;
				sel_b = ctl.b;
				op    = ctl.op;
				if ((step_q == cpc_pkg::STEP_EVAL) && !face_last) begin
					rd_addr = face_q + cpc_pkg::FACE_AW'(1);
				end
			end
			default: begin
				busy = 1'b0;
			end
		endcase
		opa = pick(sel_a, resolution, rd, dx_q, dy_q, dz_q, r2_q, s2_q, mag_q);
		opb = pick(sel_b, resolution, rd, dx_q, dy_q, dz_q, r2_q, s2_q, mag_q);
	end

	// Face verdict from the accumulated |d|^2 - r^2*|S|^2.
	always_comb begin
		d_raw    = acc_q[cpc_pkg::D_W-1:0];
		d_abs    = acc_q[cpc_pkg::ACC_W-1] ? (~d_raw + cpc_pkg::D_W'(1)) : d_raw;
		far      = !acc_q[cpc_pkg::ACC_W-1] && (|acc_q);
		inside_n = inside_q && far && neg_q;
		nout_n   = nout_q && !(far && !neg_q && dnz_q);
		near_n   = near_q || !far;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpc_pkg::SEQ_IDLE;
			step_q  <= '0;
			face_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			// A result is due after the last face, or at once with no faces.
			done_q  <= ((state_q == cpc_pkg::SEQ_IDLE) && query_go && (nfaces == '0))
				|| (eval && face_last);
			if (state_q == cpc_pkg::SEQ_IDLE) begin
				step_q <= '0;
				face_q <= '0;
			end else if (step_q == cpc_pkg::STEP_EVAL) begin
				step_q <= '0;
				face_q <= face_q + cpc_pkg::FACE_AW'(1);
			end else begin
				step_q <= step_q + cpc_pkg::STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		dx_q <= {px_q[cpc_pkg::COORD_W-1], px_q} - {rd.cx[cpc_pkg::COORD_W-1], rd.cx};
		dy_q <= {py_q[cpc_pkg::COORD_W-1], py_q} - {rd.cy[cpc_pkg::COORD_W-1], rd.cy};
		dz_q <= {pz_q[cpc_pkg::COORD_W-1], pz_q} - {rd.cz[cpc_pkg::COORD_W-1], rd.cz};
		if (query_go) begin
			px_q        <= cmd.pos_x;
			py_q        <= cmd.pos_y;
			pz_q        <= cmd.pos_z;
			last_face_q <= nlast[cpc_pkg::FACE_AW-1:0];
			inside_q    <= 1'b1;
			nout_q      <= 1'b1;
			near_q      <= 1'b0;
			result_q    <= '{1'b1, 1'b1, 1'b0};
		end
		case (op_s1.sv)
			cpc_pkg::SV_R2: r2_q <= prod_s1[cpc_pkg::R2_W-1:0];
			cpc_pkg::SV_S2: s2_q <= acc_q[cpc_pkg::S2_W-1:0];
			cpc_pkg::SV_D: begin
				neg_q <= acc_q[cpc_pkg::ACC_W-1];
				dnz_q <= |d_raw;
				mag_q <= d_abs[cpc_pkg::MAG_W-1:0];
			end
			default: begin
			end
		endcase
		if (eval) begin
			inside_q <= inside_n;
			nout_q   <= nout_n;
			near_q   <= near_n;
			result_q <= '{inside_n, nout_n, nout_n && near_n};
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

>>> src/convex_polyhedron_point_classifier_unit.sv
// Top level of the convex polyhedron point classifier: configuration
// registers, face table, shared multiply-accumulate unit and sequencer.
// Depends on cpc_pkg, cpc_face_mem, cpc_mac and cpc_seq.
//
// Usage. A command word is taken at a rising edge where start is high and
// busy is low. A word with action LOAD writes its center and area vector
// into table slot face_index in that same edge; it returns no result and
// leaves busy low, so loads may follow one another every cycle. A word with
// action QUERY tests its point against the first face_count faces (at most
// 64) and returns one word on result, marked by done for exactly one cycle.
// The receiver cannot hold a result off; it must take it in that cycle.
//
// Timing. Every face makes thirteen passes through the single 34x34
// multiplier with its 132-bit accumulator; then the product register is
// drained and the face is judged. Busy stays high until the last active
// face is judged, and done is registered from that judgment; with no
// active faces done follows in the next cycle. A new command may be taken
// in the cycle done is shown. The multiplier is the one unit that sets the
// pace of a query.
//
// The user must write the resolution and face count registers (cfg_we,
// cfg_index, cfg_data) only while the block is idle; the block does not
// enforce it. Reset clears both registers and the control state; the face
// table is not cleared and every slot must be loaded before a query uses it.
`default_nettype none

module convex_polyhedron_point_classifier_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire cpc_pkg::in_word_t                 cmd,
	output logic                                   busy,
	output logic                                   done,
	output cpc_pkg::out_word_t                     result,
	input  wire logic                              cfg_we,
	input  wire logic [cpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [cpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [cpc_pkg::RES_W-1:0]  resolution_q;
	logic [cpc_pkg::FCNT_W-1:0] face_count_q;

	logic                                 accept;
	logic                                 load_go;
	logic                                 query_go;
	cpc_pkg::face_t                       wface;
	cpc_pkg::face_t                       rface;
	logic [cpc_pkg::FACE_AW-1:0]          rd_addr;
	logic signed [cpc_pkg::OPND_W-1:0]    opa, opb;
	cpc_pkg::mac_op_t                     op;
	cpc_pkg::mac_op_t                     op_s1;
	logic signed [cpc_pkg::PROD_W-1:0]    prod_s1;
	logic [cpc_pkg::ACC_W-1:0]            acc_q;

	// A command word is taken only while the sequencer is idle; the action
	// field then decides between a table write and a query.
	assign accept   = start && !busy;
	assign load_go  = accept && (cmd.action == cpc_pkg::ACT_LOAD);
	assign query_go = accept && (cmd.action == cpc_pkg::ACT_QUERY);

	// Configuration registers. The index decodes one register per code.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resolution_q <= '0;
			face_count_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cpc_pkg::CFG_RESOLUTION: resolution_q <= cfg_data[cpc_pkg::RES_W-1:0];
				cpc_pkg::CFG_FACE_COUNT: face_count_q <= cfg_data[cpc_pkg::FCNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The table row holds the center and the area vector of one face.
	assign wface = '{cmd.pos_x, cmd.pos_y, cmd.pos_z, cmd.area_x, cmd.area_y, cmd.area_z};

	cpc_face_mem u_mem (
		.clk   (clk),
		.we    (load_go),
		.waddr (cmd.face_index),
		.wdata (wface),
		.raddr (rd_addr),
		.rdata (rface)
	);

	cpc_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.opa     (opa),
		.opb     (opb),
		.op      (op),
		.op_s1   (op_s1),
		.prod_s1 (prod_s1),
		.acc_q   (acc_q)
	);

	cpc_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.query_go   (query_go),
		.cmd        (cmd),
		.resolution (resolution_q),
		.face_count (face_count_q),
		.rd         (rface),
		.rd_addr    (rd_addr),
		.opa        (opa),
		.opb        (opb),
		.op         (op),
		.op_s1      (op_s1),
		.prod_s1    (prod_s1),
		.acc_q      (acc_q),
		.busy       (busy),
		.done       (done),
		.result     (result)
	);

	// A result word only ends a query: either the sequencer was running or
	// a query with no active faces was taken in the previous cycle.
	a_done_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start && (cmd.action == cpc_pkg::ACT_QUERY))))
		else $error("result word without a preceding query");

	// A point inside beyond tolerance on every face cannot be outside or near.
	a_inside_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.inside_res) |-> (result.not_outside && !result.on_boundary))
		else $error("inside flag contradicts the other flags");

	// A face load never starts the sequencer and never yields a result.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.action == cpc_pkg::ACT_LOAD)) |=> (!busy && !done))
		else $error("face load started work or produced a result");

	// A taken query either runs or answers at once.
	a_query_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.action == cpc_pkg::ACT_QUERY)) |=> (busy || done))
		else $error("query was dropped");

endmodule

`default_nettype wire
